@@ rtl/sss_pkg.sv @@
package sss_pkg;

  localparam int LEN_W  = 13;
  localparam int KIND_W = 2;

  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BQUOTE = 8'h60;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_NL     = 8'h0A;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_NAME,
    PH_SUB,
    PH_DONE
  } phase_t;

  typedef enum logic [KIND_W-1:0] {
    K_TOP,
    K_DQ,
    K_PAREN,
    K_BRACE
  } kind_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       word_end;
  } in_t;

  typedef struct packed {
    logic             name_valid;
    logic [LEN_W-1:0] name_length;
    logic             has_subscript;
    logic [LEN_W-1:0] subscript_length;
    logic [LEN_W-1:0] consumed_length;
    logic             overflow;
  } out_t;

  // stack commands from the scanner
  typedef struct packed {
    logic push;
    logic pop;
    logic write_top;
    logic clear;
  } stk_op_t;

  // stack status back to the scanner
  typedef struct packed {
    logic nonempty;
    logic full;
  } stk_stat_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_UNDER;
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || (c >= 8'h30 && c <= 8'h39);
  endfunction

endpackage

@@ rtl/sss_stack.sv @@
module sss_stack import sss_pkg::*; #(
  parameter int STACK_DEPTH = 16,
  parameter int EW          = 14
) (
  input  logic          clk,
  input  logic          rst_n,
  input  stk_op_t       op,
  input  logic [EW-1:0] wdata,
  output logic [EW-1:0] top,
  output stk_stat_t     stat
);

  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  logic [EW-1:0]  mem [STACK_DEPTH];
  logic [SPW-1:0] sp_r, sp_nxt;
  logic [SPW-1:0] sp_m1, rd_full;
  logic [EW-1:0]  top_r, top_nxt;
  logic [EW-1:0]  rd_q;
  logic           byp_r;
  logic [EW-1:0]  byp_d_r;
  logic [EW-1:0]  below;
  logic           full, wen;
  logic [AW-1:0]  waddr, raddr;

  // top entry lives in top_r, memory holds the entries beneath it
  assign full    = (sp_r == SPW'(STACK_DEPTH));
  assign sp_m1   = sp_r - SPW'(1);
  assign wen     = op.push && !full && (sp_r != '0);
  assign waddr   = sp_m1[AW-1:0];
  assign rd_full = sp_nxt - SPW'(2);
  assign raddr   = rd_full[AW-1:0];
  assign below   = byp_r ? byp_d_r : rd_q;

  always_comb begin
    sp_nxt  = sp_r;
    top_nxt = top_r;
    if (op.clear) begin
      sp_nxt = '0;
    end else if (op.push && !full) begin
      sp_nxt  = sp_r + SPW'(1);
      top_nxt = wdata;
    end else if (op.pop) begin
      sp_nxt  = sp_m1;
      top_nxt = below;
    end else if (op.write_top) begin
      top_nxt = wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0;
    end else begin
      sp_r <= sp_nxt;
    end
  end

  // entry below the next top, read ahead with write-first bypass
  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= top_r;
    end
    rd_q    <= mem[raddr];
    byp_r   <= wen && (waddr == raddr);
    byp_d_r <= top_r;
    top_r   <= top_nxt;
  end

  assign top           = top_r;
  assign stat.nonempty = (sp_r != '0);
  assign stat.full     = full;

endmodule

@@ rtl/sss_scan.sv @@
module sss_scan import sss_pkg::*; #(
  parameter int MAX_WORD   = 4096,
  parameter int COUNT_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_fire,
  input  in_t                         in_item,
  input  logic [KIND_W+COUNT_BITS-1:0] top_entry,
  input  stk_stat_t                   stk_stat,
  output stk_op_t                     stk_op,
  output logic [KIND_W+COUNT_BITS-1:0] stk_wdata,
  output logic                        res_valid,
  output out_t                        res
);

  localparam int PW = $clog2(MAX_WORD + 1);
  localparam int EW = KIND_W + COUNT_BITS;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [PW-1:0] MAXW = PW'(MAX_WORD);

  phase_t phase_r, phase_nxt;
  logic [PW-1:0]         pos_r, pos_nxt, ident_r, ident_nxt, close_r, close_nxt;
  logic [COUNT_BITS-1:0] brk_r, brk_nxt;
  logic sq_r, sq_nxt, bq_r, bq_nxt, esc_r, esc_nxt, dol_r, dol_nxt, ovf_r, ovf_nxt;
  logic sub_done;
  logic [PW-1:0]         fin_ident, fin_close;
  logic                  fin_ovf;
  logic [7:0]            c;
  kind_t                 kind;
  logic [COUNT_BITS-1:0] depth, depth_nxt, brk_dec;
  logic [7:0]            opener, closer;
  logic [PW:0]           close_p1;
  logic [PW-1:0]         sub_len, consumed;
  logic [LEN_W+PW-1:0]   ext_ident, ext_sub, ext_cons;

  assign c      = in_item.text_byte;
  assign kind   = stk_stat.nonempty ? kind_t'(top_entry[EW-1 -: KIND_W]) : K_TOP;
  assign depth  = top_entry[COUNT_BITS-1:0];
  assign opener = (kind == K_PAREN) ? CH_LPAREN : CH_LBRACE;
  assign closer = (kind == K_PAREN) ? CH_RPAREN : CH_RBRACE;
  assign brk_dec = (brk_r != '0) ? brk_r - COUNT_BITS'(1) : brk_r;

  // datapath and stack commands
  always_comb begin
    pos_nxt   = pos_r;
    ident_nxt = ident_r;
    close_nxt = close_r;
    brk_nxt   = brk_r;
    sq_nxt    = sq_r;
    bq_nxt    = bq_r;
    esc_nxt   = esc_r;
    dol_nxt   = dol_r;
    ovf_nxt   = ovf_r;
    sub_done  = 1'b0;
    stk_op    = '0;
    stk_wdata = '0;
    depth_nxt = depth;
    if (in_fire) begin
      if (pos_r >= MAXW) begin
        ovf_nxt = 1'b1;
      end else begin
        pos_nxt = pos_r + PW'(1);
      end
      case (phase_r)
        PH_FIRST: begin
          if (is_alpha(c)) ident_nxt = PW'(1);
        end
        PH_NAME: begin
          if (is_word(c)) begin
            if (ident_r < MAXW) ident_nxt = ident_r + PW'(1);
            else ovf_nxt = 1'b1;
          end else if (c == CH_LBRACK) begin
            brk_nxt = COUNT_BITS'(1);
          end
        end
        PH_SUB: begin
          if (esc_r) begin
            esc_nxt = 1'b0;
          end else if (sq_r) begin
            if (c == CH_SQUOTE) sq_nxt = 1'b0;
          end else if (bq_r) begin
            if (c == CH_BQUOTE) bq_nxt = 1'b0;
          end else begin
            dol_nxt = 1'b0;
            if (dol_r && (c == CH_LPAREN || c == CH_LBRACE)) begin
              if (stk_stat.full) ovf_nxt = 1'b1;
              else stk_op.push = 1'b1;
              stk_wdata = {(c == CH_LPAREN) ? K_PAREN : K_BRACE, COUNT_BITS'(1)};
            end else if (c == CH_BSLASH) begin
              esc_nxt = 1'b1;
            end else if (c == CH_BQUOTE) begin
              bq_nxt = 1'b1;
            end else if (c == CH_SQUOTE && kind != K_DQ) begin
              sq_nxt = 1'b1;
            end else if (c == CH_DOLLAR) begin
              dol_nxt = 1'b1;
            end else if (c == CH_DQUOTE) begin
              if (kind == K_DQ) begin
                stk_op.pop = 1'b1;
              end else begin
                if (stk_stat.full) ovf_nxt = 1'b1;
                else stk_op.push = 1'b1;
                stk_wdata = {K_DQ, COUNT_BITS'(1)};
              end
            end else if (kind == K_TOP) begin
              if (c == CH_NL) begin
                sub_done = 1'b1;
              end else if (c == CH_LBRACK) begin
                if (brk_r < CNT_MAX) brk_nxt = brk_r + COUNT_BITS'(1);
                else ovf_nxt = 1'b1;
              end else if (c == CH_RBRACK) begin
                brk_nxt = brk_dec;
                if (brk_dec == '0) begin
                  close_nxt = pos_r;
                  sub_done  = 1'b1;
                end
              end
            end else if (kind != K_DQ) begin
              if (c == opener) begin
                if (depth < CNT_MAX) depth_nxt = depth + COUNT_BITS'(1);
                else ovf_nxt = 1'b1;
                stk_op.write_top = 1'b1;
              end else if (c == closer) begin
                if (depth != '0) depth_nxt = depth - COUNT_BITS'(1);
                if (depth_nxt == '0) stk_op.pop = 1'b1;
                else stk_op.write_top = 1'b1;
              end
              if (stk_op.write_top) stk_wdata = {kind, depth_nxt};
            end
          end
        end
        default: ;
      endcase
    end
    fin_ident = ident_nxt;
    fin_close = close_nxt;
    fin_ovf   = ovf_nxt;
    // word done: everything back to the start of a word
    if (in_fire && in_item.word_end) begin
      pos_nxt   = '0;
      ident_nxt = '0;
      close_nxt = '0;
      brk_nxt   = '0;
      sq_nxt    = 1'b0;
      bq_nxt    = 1'b0;
      esc_nxt   = 1'b0;
      dol_nxt   = 1'b0;
      ovf_nxt   = 1'b0;
      stk_op.clear = 1'b1;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    if (in_fire) begin
      if (in_item.word_end) begin
        phase_nxt = PH_FIRST;
      end else begin
        case (phase_r)
          PH_FIRST: phase_nxt = is_alpha(c) ? PH_NAME : PH_DONE;
          PH_NAME: begin
            if (!is_word(c)) phase_nxt = (c == CH_LBRACK) ? PH_SUB : PH_DONE;
          end
          PH_SUB: begin
            if (sub_done) phase_nxt = PH_DONE;
          end
          default: phase_nxt = phase_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
      pos_r   <= '0;
      ident_r <= '0;
      close_r <= '0;
      brk_r   <= '0;
      sq_r    <= 1'b0;
      bq_r    <= 1'b0;
      esc_r   <= 1'b0;
      dol_r   <= 1'b0;
      ovf_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      ident_r <= ident_nxt;
      close_r <= close_nxt;
      brk_r   <= brk_nxt;
      sq_r    <= sq_nxt;
      bq_r    <= bq_nxt;
      esc_r   <= esc_nxt;
      dol_r   <= dol_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // result of the finished word
  assign close_p1 = {1'b0, fin_close} + (PW + 1)'(1);
  assign sub_len  = (fin_close > fin_ident) ? fin_close - fin_ident - PW'(1) : '0;
  always_comb begin
    if (fin_close == '0) begin
      consumed = fin_ident;
    end else if (close_p1 > {1'b0, MAXW}) begin
      consumed = MAXW;
    end else begin
      consumed = close_p1[PW-1:0];
    end
  end

  assign ext_ident = {{LEN_W{1'b0}}, fin_ident};
  assign ext_sub   = {{LEN_W{1'b0}}, sub_len};
  assign ext_cons  = {{LEN_W{1'b0}}, consumed};

  assign res_valid            = in_fire && in_item.word_end;
  assign res.name_valid       = (fin_ident != '0);
  assign res.name_length      = ext_ident[LEN_W-1:0];
  assign res.has_subscript    = (fin_close != '0);
  assign res.subscript_length = ext_sub[LEN_W-1:0];
  assign res.consumed_length  = ext_cons[LEN_W-1:0];
  assign res.overflow         = fin_ovf;

endmodule

@@ rtl/shell_subscript_scanner.sv @@
// Shell array subscript scanner: one byte of a shell word per input transaction, the last
// byte flagged by word_end. The block finds the leading identifier and, if '[' follows it,
// the matching ']', honoring backslash escapes, single, double and back quotes and nested
// $( ) / ${ } substitutions held on a context stack of STACK_DEPTH entries. A byte is taken
// every cycle with no gaps between words; exactly one result transaction leaves per word,
// held in the output register or, while that one holds a result, in the skid entry. The top
// stack entry sits in a register, the entry beneath it is read ahead from the stack memory
// by a registered read with a bypass for a same-cycle write, so pushes and pops run at full
// byte rate. A result register plus one skid entry let input keep flowing while a result
// waits; input stalls only when both hold a result. No clearing pass after reset is needed.
module shell_subscript_scanner import sss_pkg::*; #(
  parameter int MAX_WORD    = 4096,
  parameter int STACK_DEPTH = 16,
  parameter int COUNT_BITS  = 12
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int EW = KIND_W + COUNT_BITS;

  logic          in_fire;
  stk_op_t       stk_op;
  stk_stat_t     stk_stat;
  logic [EW-1:0] stk_wdata, stk_top;
  logic          res_valid;
  out_t          res;

  // output register and skid entry
  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  out_t out_data_r, out_data_nxt;
  out_t skid_data_r;
  logic out_fire, out_load;

  assign in_stall = skid_valid_r;
  assign in_fire  = in_valid && !in_stall;

  sss_scan #(
    .MAX_WORD   (MAX_WORD),
    .COUNT_BITS (COUNT_BITS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_item   (in_data),
    .top_entry (stk_top),
    .stk_stat  (stk_stat),
    .stk_op    (stk_op),
    .stk_wdata (stk_wdata),
    .res_valid (res_valid),
    .res       (res)
  );

  sss_stack #(
    .STACK_DEPTH (STACK_DEPTH),
    .EW          (EW)
  ) u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (stk_op),
    .wdata (stk_wdata),
    .top   (stk_top),
    .stat  (stk_stat)
  );

  assign out_fire = out_valid_r && !out_stall;
  // output register free this cycle
  assign out_load = !out_valid_r || out_fire;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    if (out_load) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = res_valid;
        out_data_nxt  = res;
      end
    end else if (res_valid) begin
      // result held downstream, park the new one
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (!out_load && res_valid) begin
      skid_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // skid entry only fills behind a held result
  a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid without a result in the output register");

  // a word with no name reports nothing else but overflow
  a_no_name : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.name_valid) |->
      (out_data.name_length == '0 && !out_data.has_subscript &&
       out_data.consumed_length == '0))
    else $error("result without a name carries lengths");

  // without a subscript the consumed length is the name length
  a_no_sub : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.has_subscript) |->
      (out_data.subscript_length == '0 &&
       out_data.consumed_length == out_data.name_length))
    else $error("result without subscript has inconsistent lengths");

endmodule

@@ test/shell_subscript_scanner_test.sv @@
module shell_subscript_scanner_test;
  import sss_pkg::*;

  // block configuration as instantiated (defaults)
  localparam int MAX_WORD    = 4096;
  localparam int STACK_DEPTH = 16;
  localparam int COUNT_MAX   = 4095;

  // predicts the scan result of each word, keeps the expected results in order
  class scan_scoreboard;
    phase_t scan_ph;
    int     pos;
    int     name_len;
    int     close_pos;
    int     brackets;
    bit     in_sq;
    bit     in_bq;
    bit     esc;
    bit     dol;
    bit     ovf;
    kind_t  ctx_kind [STACK_DEPTH];
    int     ctx_depth [STACK_DEPTH];
    int     sp;
    out_t   expected_scans [$];
    int     mismatches;

    function new();
      clear();
      mismatches = 0;
    endfunction

    function void clear();
      scan_ph   = PH_FIRST;
      pos       = 0;
      name_len  = 0;
      close_pos = 0;
      brackets  = 0;
      in_sq     = 0;
      in_bq     = 0;
      esc       = 0;
      dol       = 0;
      ovf       = 0;
      sp        = 0;
    endfunction

    function bit ident_head(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
    endfunction

    function bit ident_tail(logic [7:0] c);
      return ident_head(c) || (c >= "0" && c <= "9");
    endfunction

    function void push_ctx(kind_t k);
      if (sp < STACK_DEPTH) begin
        ctx_kind[sp]  = k;
        ctx_depth[sp] = 1;
        sp++;
      end else begin
        ovf = 1;
      end
    endfunction

    function void scan_sub(logic [7:0] c, int idx);
      kind_t      k;
      int         d;
      logic [7:0] opener;
      logic [7:0] closer;
      if (esc) begin
        esc = 0;
        return;
      end
      if (in_sq) begin
        if (c == CH_SQUOTE) in_sq = 0;
        return;
      end
      if (in_bq) begin
        if (c == CH_BQUOTE) in_bq = 0;
        return;
      end
      k = (sp != 0) ? ctx_kind[sp-1] : K_TOP;
      if (dol) begin
        dol = 0;
        if (c == CH_LPAREN) begin
          push_ctx(K_PAREN);
          return;
        end
        if (c == CH_LBRACE) begin
          push_ctx(K_BRACE);
          return;
        end
      end
      if (c == CH_BSLASH) begin
        esc = 1;
        return;
      end
      if (c == CH_BQUOTE) begin
        in_bq = 1;
        return;
      end
      if (c == CH_SQUOTE && k != K_DQ) begin
        in_sq = 1;
        return;
      end
      if (c == CH_DOLLAR) begin
        dol = 1;
        return;
      end
      if (c == CH_DQUOTE) begin
        if (k == K_DQ) sp--;
        else push_ctx(K_DQ);
        return;
      end
      if (k == K_TOP) begin
        if (c == CH_NL) begin
          scan_ph = PH_DONE;
        end else if (c == CH_LBRACK) begin
          if (brackets < COUNT_MAX) brackets++;
          else ovf = 1;
        end else if (c == CH_RBRACK) begin
          if (brackets > 0) brackets--;
          if (brackets == 0) begin
            close_pos = idx;
            scan_ph   = PH_DONE;
          end
        end
      end else if (k != K_DQ) begin
        opener = (k == K_PAREN) ? CH_LPAREN : CH_LBRACE;
        closer = (k == K_PAREN) ? CH_RPAREN : CH_RBRACE;
        d = ctx_depth[sp-1];
        if (c == opener) begin
          if (d < COUNT_MAX) d++;
          else ovf = 1;
        end else if (c == closer) begin
          if (d > 0) d--;
          if (d == 0) begin
            sp--;
            return;
          end
        end
        ctx_depth[sp-1] = d;
      end
    endfunction

    // one accepted input transaction
    function void note_byte(in_t it);
      logic [7:0] c;
      int         idx;
      int         sub_len;
      int         consumed;
      out_t       r;
      c   = it.text_byte;
      idx = pos;
      if (pos >= MAX_WORD) ovf = 1;
      else pos++;
      case (scan_ph)
        PH_FIRST: begin
          if (ident_head(c)) begin
            name_len = 1;
            scan_ph  = PH_NAME;
          end else begin
            scan_ph = PH_DONE;
          end
        end
        PH_NAME: begin
          if (ident_tail(c)) begin
            if (name_len < MAX_WORD) name_len++;
            else ovf = 1;
          end else if (c == CH_LBRACK) begin
            scan_ph  = PH_SUB;
            brackets = 1;
          end else begin
            scan_ph = PH_DONE;
          end
        end
        PH_SUB: scan_sub(c, idx);
        default: ;
      endcase
      if (!it.word_end) return;
      sub_len  = 0;
      consumed = name_len;
      if (close_pos != 0) begin
        if (close_pos > name_len) sub_len = close_pos - name_len - 1;
        consumed = close_pos + 1;
        if (consumed > MAX_WORD) consumed = MAX_WORD;
      end
      r.name_valid       = (name_len != 0);
      r.name_length      = LEN_W'(name_len);
      r.has_subscript    = (close_pos != 0);
      r.subscript_length = LEN_W'(sub_len);
      r.consumed_length  = LEN_W'(consumed);
      r.overflow         = ovf;
      expected_scans.push_back(r);
      clear();
    endfunction

    function void field_error(string field, logic [LEN_W-1:0] want, logic [LEN_W-1:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s at %0t: expected %0d, got %0d", field, $time, want, got);
    endfunction

    // one accepted result transaction
    function void check_scan(out_t got);
      out_t want;
      if (expected_scans.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected scan result at %0t: %p", $time, got);
        return;
      end
      want = expected_scans.pop_front();
      if (got.name_valid !== want.name_valid)
        field_error("name_valid", LEN_W'(want.name_valid), LEN_W'(got.name_valid));
      if (got.name_length !== want.name_length)
        field_error("name_length", want.name_length, got.name_length);
      if (got.has_subscript !== want.has_subscript)
        field_error("has_subscript", LEN_W'(want.has_subscript), LEN_W'(got.has_subscript));
      if (got.subscript_length !== want.subscript_length)
        field_error("subscript_length", want.subscript_length, got.subscript_length);
      if (got.consumed_length !== want.consumed_length)
        field_error("consumed_length", want.consumed_length, got.consumed_length);
      if (got.overflow !== want.overflow)
        field_error("overflow", LEN_W'(want.overflow), LEN_W'(got.overflow));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  scan_scoreboard sb = new();

  // idle percentages per phase; receiver side updated with nonblocking writes
  int   send_idle_pct = 19;
  int   recv_idle_pct = 61;
  bit   hold_request  = 0;
  logic long_hold     = 1'b0;
  int   bytes_offered = 0;

  // bytes of the word being sent
  logic [7:0] word_q [$];

  shell_subscript_scanner uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watch both channels; a transaction counts where valid is high and stall low
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_byte(in_data);
      if (out_valid && !out_stall) sb.check_scan(out_data);
    end
  end

  // result side backpressure, with one long hold-off to fill the block
  always @(posedge clk) begin
    if (long_hold) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // long hold-off counted here while the sender keeps offering bytes
  initial begin
    wait (hold_request);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (300) @(posedge clk);
    long_hold <= 1'b0;
  end

  // offer one byte, idling at random beforehand, then wait for acceptance
  task automatic send_byte(input in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  // send word_q, flagging its last byte
  task automatic send_word();
    in_t it;
    bytes_offered += word_q.size();
    foreach (word_q[i]) begin
      it.text_byte = word_q[i];
      it.word_end  = (i == word_q.size() - 1);
      send_byte(it);
    end
  endtask

  task automatic send_text(input string s);
    word_q.delete();
    for (int i = 0; i < s.len(); i++) word_q.push_back(s[i]);
    send_word();
  endtask

  function automatic logic [7:0] pick_from(input string s);
    return s[$urandom_range(s.len() - 1)];
  endfunction

  function automatic logic [7:0] plain_char();
    return pick_from("abcxyz019 +-=.,:@");
  endfunction

  function automatic logic [7:0] name_head();
    return pick_from("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_");
  endfunction

  function automatic logic [7:0] name_tail();
    return pick_from("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789");
  endfunction

  // mostly well-formed subscripts with random content, some noise and broken words
  task automatic build_random_word();
    int         roll;
    int         n;
    int         top;
    int         limit;
    int         sel;
    int         cut;
    logic [7:0] cl;
    logic [7:0] closers [32];
    word_q.delete();
    roll = $urandom_range(99);
    if (roll < 12) begin
      // raw noise, any byte value
      n = $urandom_range(1, 8);
      repeat (n) word_q.push_back(8'($urandom));
      return;
    end
    word_q.push_back(name_head());
    n = $urandom_range(0, 4);
    repeat (n) word_q.push_back(name_tail());
    if (roll >= 22) begin
      word_q.push_back(CH_LBRACK);
      top        = 1;
      closers[0] = CH_RBRACK;
      // deep nesting now and then, past the stack depth
      limit = ($urandom_range(9) == 0) ? 20 : 5;
      n     = $urandom_range(1, 12);
      repeat (n) begin
        cl = closers[top-1];
        case ($urandom_range(9))
          3: begin
            word_q.push_back(CH_BSLASH);
            word_q.push_back(8'($urandom));
          end
          4: begin
            // single quotes are literal inside double quotes
            if (cl != CH_DQUOTE) begin
              word_q.push_back(CH_SQUOTE);
              repeat ($urandom_range(0, 3)) word_q.push_back(plain_char());
              word_q.push_back(CH_SQUOTE);
            end else begin
              word_q.push_back(plain_char());
            end
          end
          5: begin
            word_q.push_back(CH_BQUOTE);
            repeat ($urandom_range(0, 3)) word_q.push_back(plain_char());
            word_q.push_back(CH_BQUOTE);
          end
          6, 7: begin
            if (top < limit) begin
              sel = $urandom_range(3);
              if (sel == 0) begin
                word_q.push_back(CH_DQUOTE);
                closers[top] = CH_DQUOTE;
              end else if (sel == 2) begin
                word_q.push_back(CH_DOLLAR);
                word_q.push_back(CH_LBRACE);
                closers[top] = CH_RBRACE;
              end else if (sel == 3 && cl == CH_RBRACK) begin
                word_q.push_back(CH_LBRACK);
                closers[top] = CH_RBRACK;
              end else if (sel == 3 && cl == CH_RPAREN) begin
                word_q.push_back(CH_LPAREN);
                closers[top] = CH_RPAREN;
              end else if (sel == 3 && cl == CH_RBRACE) begin
                word_q.push_back(CH_LBRACE);
                closers[top] = CH_RBRACE;
              end else begin
                word_q.push_back(CH_DOLLAR);
                word_q.push_back(CH_LPAREN);
                closers[top] = CH_RPAREN;
              end
              top++;
            end
          end
          8: begin
            if (top > 1) begin
              top--;
              word_q.push_back(closers[top]);
            end
          end
          9: begin
            // dollar not followed by an opener
            word_q.push_back(CH_DOLLAR);
            word_q.push_back(plain_char());
          end
          default: word_q.push_back(plain_char());
        endcase
      end
      while (top > 0) begin
        top--;
        word_q.push_back(closers[top]);
      end
    end
    // trailing bytes after the name or the close bracket
    if ($urandom_range(99) < 30)
      repeat ($urandom_range(1, 3)) word_q.push_back(8'($urandom));
    // break some words: truncate, stray newline or a random byte
    if ($urandom_range(99) < 15 && word_q.size() > 1) begin
      cut = $urandom_range(word_q.size() - 1);
      case ($urandom_range(2))
        0: while (word_q.size() > cut + 1) void'(word_q.pop_back());
        1: word_q.insert(cut, CH_NL);
        default: word_q[cut] = 8'($urandom);
      endcase
    end
  endtask

  task automatic run_random(input int byte_goal);
    while (bytes_offered < byte_goal) begin
      build_random_word();
      send_word();
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // first phase: sender idles lightly, receiver heavily
    send_text("a");
    send_text("_");
    send_text("9x");
    word_q.delete();
    word_q.push_back(8'h00);
    send_word();
    word_q.delete();
    word_q.push_back(8'hFF);
    send_word();
    send_text("ab[1]");
    send_text("ab[1]tail");
    send_text("ab-c");
    send_text("x[a[b]c]");
    send_text("x[a\nb]");
    send_text("x[1");
    send_text("x[\"]\"]");
    send_text("x['a]']");
    send_text("x[`]`]");
    send_text("x[$(])]");
    send_text("x[${]}]");
    send_text("x[\\]]");
    send_text("x[$]");
    send_text("x[\\");
    send_text("x$");
    send_text("x[$(\n)]");
    send_text("x[$((1))]");
    send_text("Z9_[${a{b}}\"$(\")\"]");
    // stack full: one push too many is dropped
    word_q.delete();
    word_q.push_back("x");
    word_q.push_back(CH_LBRACK);
    repeat (STACK_DEPTH + 1) begin
      word_q.push_back(CH_DOLLAR);
      word_q.push_back(CH_LPAREN);
    end
    repeat (STACK_DEPTH + 1) word_q.push_back(CH_RPAREN);
    word_q.push_back(CH_RBRACK);
    send_word();
    run_random(420);

    // second phase: roles swapped
    send_idle_pct = 61;
    recv_idle_pct <= 19;
    run_random(840);

    // last phase: no idling, long hold-off on the result side
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    hold_request = 1;
    run_random(1250);
    in_valid <= 1'b0;

    while (sb.expected_scans.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_scans.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // run limit, far above the slowest correct run
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule

@@ files.f @@
rtl/sss_pkg.sv
rtl/sss_stack.sv
rtl/sss_scan.sv
rtl/shell_subscript_scanner.sv
test/shell_subscript_scanner_test.sv
